// ===== rtl/lit_pkg.sv =====
// Shared types, register map and constants for the leaky integrator tier detector.
`default_nettype none

package lit_pkg;

    typedef struct packed {
        logic signed [31:0] smoke_weight;
        logic signed [31:0] fire_weight;
        logic        [4:0]  leak_shift_amount;
        logic signed [31:0] weak_threshold;
        logic signed [31:0] strong_threshold;
        logic signed [31:0] potential_after_fire;
        logic        [7:0]  refractory_length;
    } lit_cfg_t;

    // Register indexes (byte address is 4 * index)
    localparam logic [2:0] REG_SMOKE_WEIGHT         = 3'd0;
    localparam logic [2:0] REG_FIRE_WEIGHT          = 3'd1;
    localparam logic [2:0] REG_LEAK_SHIFT_AMOUNT    = 3'd2;
    localparam logic [2:0] REG_WEAK_THRESHOLD       = 3'd3;
    localparam logic [2:0] REG_STRONG_THRESHOLD     = 3'd4;
    localparam logic [2:0] REG_POTENTIAL_AFTER_FIRE = 3'd5;
    localparam logic [2:0] REG_REFRACTORY_LENGTH    = 3'd6;

    // Register reset values
    localparam logic signed [31:0] RST_SMOKE_WEIGHT         = 32'sd22937;
    localparam logic signed [31:0] RST_FIRE_WEIGHT          = 32'sd58982;
    localparam logic        [4:0]  RST_LEAK_SHIFT_AMOUNT    = 5'd4;
    localparam logic signed [31:0] RST_WEAK_THRESHOLD       = 32'sd52428;
    localparam logic signed [31:0] RST_STRONG_THRESHOLD     = 32'sd196608;
    localparam logic signed [31:0] RST_POTENTIAL_AFTER_FIRE = 32'sd0;
    localparam logic        [7:0]  RST_REFRACTORY_LENGTH    = 8'd8;

    localparam logic       MODE_OBSERVE = 1'b0;
    localparam logic       MODE_TICK    = 1'b1;

    localparam logic [1:0] CLASS_SMOKE  = 2'd0;
    localparam logic [1:0] CLASS_FIRE   = 2'd1;

    localparam logic [1:0] TIER_SILENT  = 2'd0;
    localparam logic [1:0] TIER_WEAK    = 2'd1;
    localparam logic [1:0] TIER_STRONG  = 2'd2;

    localparam logic [31:0] Q16_MAX = 32'h7fff_ffff;
    localparam logic [31:0] Q16_MIN = 32'h8000_0000;

    // Saturate a 36-bit two's complement value to the signed 32-bit range
    function automatic logic [31:0] sat32(input logic [35:0] x);
        logic [31:0] res;
        if (x[35] && (x[34:31] != 4'hf)) begin
            res = Q16_MIN;
        end else if (!x[35] && (x[34:31] != 4'h0)) begin
            res = Q16_MAX;
        end else begin
            res = x[31:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/leaky_integrator_tier_detector.sv =====
// Top level of the leaky integrator tier detector: input register, datapath, result register.
`default_nettype none

// Leaky integrate-and-fire detector in signed Q16.16. An observe word (mode 0) with class
// smoke or fire adds weight*confidence, saturated, to a pending injection and gives no
// result. A tick word (mode 1) leaks the potential by v >> leak_shift_amount, adds and
// clears the injection, clamps at zero and returns one tier (silent, weak, strong); a
// strong tier reloads the potential and starts the refractory count, during which ticks
// report at most weak. One word is taken every cycle unless stalled: each word is held in the
// input register and is finished in a single pass of the multiply, add and compare logic
// into the state and result registers, from which a tick's tier is shown.
// A stalled result holds the next tick in the input register, and the input stalls behind
// it; observe words keep flowing until such a tick arrives.
module leaky_integrator_tier_detector (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_mode,
    input  wire logic [1:0]  s_detect_class,
    input  wire logic [16:0] s_confidence,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [1:0]  m_tier,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import lit_pkg::*;

    lit_cfg_t cfg;

    lit_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Input register
    logic        in_v_reg;
    logic        in_mode_reg;
    logic [1:0]  in_class_reg;
    logic [16:0] in_conf_reg;

    // State and result register
    logic [31:0] potential_reg;
    logic [31:0] pending_reg;
    logic [7:0]  refr_reg;
    logic        out_v_reg;
    logic [1:0]  tier_reg;

    logic        consume;
    logic        accept;

    assign consume = in_v_reg && ((in_mode_reg == MODE_OBSERVE) || !out_v_reg || m_ready);
    assign s_ready = aresetn && (!in_v_reg || consume);
    assign accept  = s_valid && s_ready;
    assign m_valid = out_v_reg;
    assign m_tier  = tier_reg;

    // Observe path: weight * confidence, floor >> 16, saturate, accumulate
    logic        use_obs;
    logic [31:0] weight;
    logic [49:0] prod;
    logic [31:0] prod_sat;
    logic [31:0] inj_next;

    assign use_obs  = (in_class_reg == CLASS_SMOKE) || (in_class_reg == CLASS_FIRE);
    assign weight   = (in_class_reg == CLASS_SMOKE) ? cfg.smoke_weight : cfg.fire_weight;
    assign prod     = {{18{weight[31]}}, weight} * {33'd0, in_conf_reg};
    assign prod_sat = sat32({{2{prod[49]}}, prod[49:16]});
    assign inj_next = sat32({{4{pending_reg[31]}}, pending_reg}
                          + {{4{prod_sat[31]}}, prod_sat});

    // Tick path: leak, inject, clamp, classify
    logic signed [31:0] leak;
    logic        [32:0] leaked;
    logic        [35:0] v_sum;
    logic        [31:0] v_sat;
    logic signed [31:0] v;
    logic               hit_weak;
    logic               hit_strong;

    assign leak       = $signed(potential_reg) >>> cfg.leak_shift_amount;
    assign leaked     = {potential_reg[31], potential_reg} - {leak[31], leak};
    assign v_sum      = {{3{leaked[32]}}, leaked} + {{4{pending_reg[31]}}, pending_reg};
    assign v_sat      = sat32(v_sum);
    assign v          = v_sat[31] ? 32'sd0 : $signed(v_sat);
    assign hit_weak   = v >= cfg.weak_threshold;
    assign hit_strong = v >= cfg.strong_threshold;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg      <= 1'b0;
            out_v_reg     <= 1'b0;
            potential_reg <= '0;
            pending_reg   <= '0;
            refr_reg      <= '0;
            tier_reg      <= TIER_SILENT;
        end else begin
            if (accept) begin
                in_v_reg     <= 1'b1;
                in_mode_reg  <= s_mode;
                in_class_reg <= s_detect_class;
                in_conf_reg  <= s_confidence;
            end else if (consume) begin
                in_v_reg <= 1'b0;
            end

            if (consume && (in_mode_reg == MODE_TICK)) begin
                out_v_reg <= 1'b1;
            end else if (m_ready) begin
                out_v_reg <= 1'b0;
            end

            if (consume) begin
                if (in_mode_reg == MODE_OBSERVE) begin
                    if (use_obs) begin
                        pending_reg <= inj_next;
                    end
                end else begin
                    pending_reg <= '0;
                    if (refr_reg != 8'd0) begin
                        refr_reg      <= refr_reg - 8'd1;
                        potential_reg <= v;
                        tier_reg      <= hit_weak ? TIER_WEAK : TIER_SILENT;
                    end else if (hit_strong) begin
                        refr_reg      <= cfg.refractory_length;
                        potential_reg <= cfg.potential_after_fire;
                        tier_reg      <= TIER_STRONG;
                    end else begin
                        potential_reg <= v;
                        tier_reg      <= hit_weak ? TIER_WEAK : TIER_SILENT;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lit_regs.sv =====
// APB configuration register file for the leaky integrator tier detector.
`default_nettype none

module lit_regs (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [4:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    output lit_pkg::lit_cfg_t      cfg
);
    import lit_pkg::*;

    lit_cfg_t   cfg_reg;
    logic [2:0] index;
    logic       wr_en;

    assign index  = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.smoke_weight         <= RST_SMOKE_WEIGHT;
            cfg_reg.fire_weight          <= RST_FIRE_WEIGHT;
            cfg_reg.leak_shift_amount    <= RST_LEAK_SHIFT_AMOUNT;
            cfg_reg.weak_threshold       <= RST_WEAK_THRESHOLD;
            cfg_reg.strong_threshold     <= RST_STRONG_THRESHOLD;
            cfg_reg.potential_after_fire <= RST_POTENTIAL_AFTER_FIRE;
            cfg_reg.refractory_length    <= RST_REFRACTORY_LENGTH;
        end else if (wr_en) begin
            case (index)
                REG_SMOKE_WEIGHT:         cfg_reg.smoke_weight         <= pwdata;
                REG_FIRE_WEIGHT:          cfg_reg.fire_weight          <= pwdata;
                REG_LEAK_SHIFT_AMOUNT:    cfg_reg.leak_shift_amount    <= pwdata[4:0];
                REG_WEAK_THRESHOLD:       cfg_reg.weak_threshold       <= pwdata;
                REG_STRONG_THRESHOLD:     cfg_reg.strong_threshold     <= pwdata;
                REG_POTENTIAL_AFTER_FIRE: cfg_reg.potential_after_fire <= pwdata;
                REG_REFRACTORY_LENGTH:    cfg_reg.refractory_length    <= pwdata[7:0];
                default: begin
                    // drop writes outside the map
                end
            endcase
        end
    end

    always_comb begin
        case (index)
            REG_SMOKE_WEIGHT:         prdata = cfg_reg.smoke_weight;
            REG_FIRE_WEIGHT:          prdata = cfg_reg.fire_weight;
            REG_LEAK_SHIFT_AMOUNT:    prdata = {27'd0, cfg_reg.leak_shift_amount};
            REG_WEAK_THRESHOLD:       prdata = cfg_reg.weak_threshold;
            REG_STRONG_THRESHOLD:     prdata = cfg_reg.strong_threshold;
            REG_POTENTIAL_AFTER_FIRE: prdata = cfg_reg.potential_after_fire;
            REG_REFRACTORY_LENGTH:    prdata = {24'd0, cfg_reg.refractory_length};
            default:                  prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/lit_checker.sv =====
// Port-level assertions for the leaky integrator tier detector, bound to the top level.
`default_nettype none

module lit_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic       s_mode,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [1:0] m_tier
);
    import lit_pkg::*;

    logic tick_acc;
    assign tick_acc = s_valid && s_ready && (s_mode == MODE_TICK);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_tier))
        else $error("result word changed while stalled");

    a_tier_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_tier == TIER_SILENT) || (m_tier == TIER_WEAK)
                 || (m_tier == TIER_STRONG))
        else $error("tier code out of range");

    // only a tick produces a result, after it passes through the input register
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid && !tick_acc && !$past(tick_acc) |=> !m_valid)
        else $error("result word without a tick");

    a_reset_empty: assert property (@(posedge aclk)
        aresetn && $past(!aresetn) |-> !m_valid)
        else $error("result valid right after reset");

endmodule

bind leaky_integrator_tier_detector lit_checker u_lit_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_mode  (s_mode),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_tier  (m_tier)
);

`default_nettype wire
